>>> sv/ldsd_pkg.sv
// Shared types and constants for the load drop stall detector.
package ldsd_pkg;

	localparam int SAMPLE_W = 10;
	localparam int CNT_W = 8;
	localparam int FRAC_W = 17;
	localparam int FRAC_SHIFT = 16;
	localparam int RING_DEPTH_DEF = 8;

	localparam logic [FRAC_W-1:0] KEEP_ONE = 17'd65536;
	localparam logic [FRAC_W-1:0] KEEP_RST = 17'd52429;
	localparam logic [CNT_W-1:0] NEEDED_RST = 8'd3;
	localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

	// configuration register indexes
	typedef enum logic [0:0] {
		CFG_KEEP = 1'b0,
		CFG_NEEDED = 1'b1
	} cfg_reg_t;

	// control bits that travel with an item down the pipe
	typedef struct packed {
		logic clear;
		logic monitor;
	} ctl_t;

endpackage

>>> sv/load_drop_stall_detector_top.sv
// Top level of the load drop stall detector: config registers and pipeline wiring.
//
// Load drop stall detector. Each item carries one load sample; the block answers with exactly
// one result item holding the truncated mean of the last RING_DEPTH samples (slots not yet
// written since reset or the last clear count as zero), the latched baseline, the confirm
// counter and a stall flag. Throughput is one item per clock while out_ready stays high; an
// item passes the ring memory read on the accepting edge, then ring update, mean multiply,
// and baseline and counter update into the result register. The samples live in a
// RING_DEPTH-entry memory with registered read; per-entry valid bits in flops make reset and
// clear take effect at once, so there is no clearing pass. Consecutive items touch different
// ring slots unless the first is a clear item, which writes nothing, so the read of one item
// never collides with the write-back of the one before it. The mean is a multiply by a fixed
// reciprocal, exact for any RING_DEPTH in 2..64. A clear item empties ring, baseline and
// counter and returns an all-zero result. Configuration: index 0 is keep_fraction (unsigned
// Q1.16, values above 1.0 act as 1.0), index 1 is confirm_needed; cfg_ready is always high and
// writes are meant to happen while no item is in flight.
module load_drop_stall_detector_top import ldsd_pkg::*; #(
	parameter int RING_DEPTH = RING_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// sample channel
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                clear,
	input  logic                monitor,
	input  logic [SAMPLE_W-1:0] load_sample,
	// result channel
	output logic                out_valid,
	input  logic                out_ready,
	output logic [SAMPLE_W-1:0] mean_load,
	output logic [SAMPLE_W-1:0] baseline_level,
	output logic                baseline_valid,
	output logic [CNT_W-1:0]    confirm_level,
	output logic                stall_res,
	// configuration write channel
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [0:0]          cfg_index,
	input  logic [FRAC_W-1:0]   cfg_data
);

	localparam int TW = SAMPLE_W + $clog2(RING_DEPTH);

	logic [FRAC_W-1:0] keep_q;
	logic [CNT_W-1:0] needed_q;

	ctl_t in_ctl;
	logic r2m_valid;
	logic r2m_ready;
	ctl_t r2m_ctl;
	logic [TW-1:0] r2m_total;
	logic m2t_valid;
	logic m2t_ready;
	ctl_t m2t_ctl;
	logic [SAMPLE_W-1:0] m2t_mean;

	// config port never stalls
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q <= KEEP_RST;
			needed_q <= NEEDED_RST;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_KEEP: begin
					keep_q <= cfg_data;
				end
				CFG_NEEDED: begin
					needed_q <= cfg_data[CNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign in_ctl.clear = clear;
	assign in_ctl.monitor = monitor;

	// ring memory and running total
	ldsd_ring #(
		.RING_DEPTH(RING_DEPTH)
	) u_ring (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_ctl(in_ctl),
		.in_sample(load_sample),
		.out_valid(r2m_valid),
		.out_ready(r2m_ready),
		.out_ctl(r2m_ctl),
		.out_total(r2m_total)
	);

	// total / RING_DEPTH
	ldsd_mean #(
		.RING_DEPTH(RING_DEPTH)
	) u_mean (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(r2m_valid),
		.in_ready(r2m_ready),
		.in_ctl(r2m_ctl),
		.in_total(r2m_total),
		.out_valid(m2t_valid),
		.out_ready(m2t_ready),
		.out_ctl(m2t_ctl),
		.out_mean(m2t_mean)
	);

	// baseline, threshold compare, confirm counter, result register
	ldsd_track u_track (
		.clk(clk),
		.arst_n(arst_n),
		.keep_fraction(keep_q),
		.confirm_needed(needed_q),
		.in_valid(m2t_valid),
		.in_ready(m2t_ready),
		.in_ctl(m2t_ctl),
		.in_mean(m2t_mean),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.mean_load(mean_load),
		.baseline_level(baseline_level),
		.baseline_valid(baseline_valid),
		.confirm_level(confirm_level),
		.stall_res(stall_res)
	);

endmodule

>>> sv/ldsd_ring.sv
// Sample ring memory, slot pointer and running total (read stage and update stage).
module ldsd_ring import ldsd_pkg::*; #(
	parameter int RING_DEPTH = RING_DEPTH_DEF,
	localparam int SW = $clog2(RING_DEPTH),
	localparam int TW = SAMPLE_W + $clog2(RING_DEPTH)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ctl_t                in_ctl,
	input  logic [SAMPLE_W-1:0] in_sample,
	output logic                out_valid,
	input  logic                out_ready,
	output ctl_t                out_ctl,
	output logic [TW-1:0]       out_total
);

	logic [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
	logic [RING_DEPTH-1:0] vld_q;
	logic [SW-1:0] slot_q;
	logic [TW-1:0] total_q;

	logic v_s1;
	ctl_t ctl_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic [SW-1:0] slot_s1;
	logic [SAMPLE_W-1:0] rdata_s1;

	logic v_s2;
	ctl_t ctl_s2;
	logic [TW-1:0] total_s2;

	logic acc;
	logic go_s1;
	logic [SAMPLE_W-1:0] old_val;
	logic [TW-1:0] total_nx;

	assign go_s1 = v_s1 && (!v_s2 || out_ready);
	assign in_ready = !v_s1 || go_s1;
	assign acc = in_valid && in_ready;

	// unwritten slots count as zero
	assign old_val = vld_q[slot_s1] ? rdata_s1 : '0;
	assign total_nx = total_q - TW'(old_val) + TW'(sample_s1);

	// memory: registered read on accept, write when the item leaves the read stage for the update stage
	always_ff @(posedge clk) begin
		if (acc) begin
			rdata_s1 <= ring_mem[slot_q];
		end
		if (go_s1 && !ctl_s1.clear) begin
			ring_mem[slot_s1] <= sample_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			slot_q <= '0;
			total_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (acc) begin
				if (in_ctl.clear || slot_q == SW'(RING_DEPTH - 1)) begin
					slot_q <= '0;
				end else begin
					slot_q <= slot_q + 1'b1;
				end
			end
			if (go_s1) begin
				if (ctl_s1.clear) begin
					vld_q <= '0;
					total_q <= '0;
				end else begin
					vld_q[slot_s1] <= 1'b1;
					total_q <= total_nx;
				end
			end
			if (acc) begin
				v_s1 <= 1'b1;
			end else if (go_s1) begin
				v_s1 <= 1'b0;
			end
			if (go_s1) begin
				v_s2 <= 1'b1;
			end else if (out_ready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ctl_s1 <= in_ctl;
			sample_s1 <= in_sample;
			slot_s1 <= slot_q;
		end
		if (go_s1) begin
			ctl_s2 <= ctl_s1;
			total_s2 <= ctl_s1.clear ? '0 : total_nx;
		end
	end

	assign out_valid = v_s2;
	assign out_ctl = ctl_s2;
	assign out_total = total_s2;

endmodule

>>> sv/ldsd_mean.sv
// Ring mean by reciprocal multiply, one registered stage.
module ldsd_mean import ldsd_pkg::*; #(
	parameter int RING_DEPTH = RING_DEPTH_DEF,
	localparam int TW = SAMPLE_W + $clog2(RING_DEPTH)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ctl_t                in_ctl,
	input  logic [TW-1:0]       in_total,
	output logic                out_valid,
	input  logic                out_ready,
	output ctl_t                out_ctl,
	output logic [SAMPLE_W-1:0] out_mean
);

	// floor(x / D) == floor(x * ceil(2^K / D) / 2^K) for all TW-bit x
	localparam int K = TW + $clog2(RING_DEPTH);
	localparam int MW = TW + 1;
	localparam longint RECIP_L = ((64'd1 << K) + RING_DEPTH - 1) / RING_DEPTH;
	localparam logic [MW-1:0] RECIP = MW'(RECIP_L);

	logic [TW+MW-1:0] prod;
	logic [SAMPLE_W-1:0] mean;
	logic v_s3;
	ctl_t ctl_s3;
	logic [SAMPLE_W-1:0] mean_s3;
	logic take;

	assign prod = {{MW{1'b0}}, in_total} * {{TW{1'b0}}, RECIP};
	assign mean = prod[K +: SAMPLE_W];

	assign in_ready = !v_s3 || out_ready;
	assign take = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (in_ready) begin
			v_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ctl_s3 <= in_ctl;
			mean_s3 <= mean;
		end
	end

	assign out_valid = v_s3;
	assign out_ctl = ctl_s3;
	assign out_mean = mean_s3;

endmodule

>>> sv/ldsd_track.sv
// Baseline latch, drop threshold, confirm counter and result register.
module ldsd_track import ldsd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [FRAC_W-1:0]   keep_fraction,
	input  logic [CNT_W-1:0]    confirm_needed,
	input  logic                in_valid,
	output logic                in_ready,
	input  ctl_t                in_ctl,
	input  logic [SAMPLE_W-1:0] in_mean,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [SAMPLE_W-1:0] mean_load,
	output logic [SAMPLE_W-1:0] baseline_level,
	output logic                baseline_valid,
	output logic [CNT_W-1:0]    confirm_level,
	output logic                stall_res
);

	logic [SAMPLE_W-1:0] base_q;
	logic flag_q;
	logic [CNT_W-1:0] cnt_q;
	logic out_valid_q;

	logic go;
	logic [FRAC_W-1:0] frac_sat;
	logic [SAMPLE_W+FRAC_W-1:0] limit_prod;
	logic [SAMPLE_W:0] limit;
	logic raise;
	logic latch;
	logic [CNT_W-1:0] cnt_nx;
	logic stall;

	assign in_ready = !out_valid_q || out_ready;
	assign go = in_valid && in_ready;

	assign frac_sat = (keep_fraction > KEEP_ONE) ? KEEP_ONE : keep_fraction;
	assign limit_prod = {{FRAC_W{1'b0}}, base_q} * {{SAMPLE_W{1'b0}}, frac_sat};
	assign limit = limit_prod[FRAC_SHIFT +: SAMPLE_W + 1];

	// a freshly latched baseline never trips: mean >= floor(mean * frac)
	assign latch = in_ctl.monitor && !flag_q && (in_mean != '0);
	assign raise = in_ctl.monitor && flag_q && ({1'b0, in_mean} < limit);

	always_comb begin
		cnt_nx = cnt_q;
		if (raise) begin
			if (cnt_q != CNT_MAX) begin
				cnt_nx = cnt_q + 1'b1;
			end
		end else if (in_ctl.monitor && flag_q && cnt_q != '0) begin
			cnt_nx = cnt_q - 1'b1;
		end
	end

	assign stall = raise && (cnt_nx >= confirm_needed);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			flag_q <= 1'b0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				out_valid_q <= in_valid;
			end
			if (go) begin
				if (in_ctl.clear) begin
					base_q <= '0;
					flag_q <= 1'b0;
					cnt_q <= '0;
				end else begin
					if (latch) begin
						base_q <= in_mean;
						flag_q <= 1'b1;
					end
					cnt_q <= cnt_nx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			if (in_ctl.clear) begin
				mean_load <= '0;
				baseline_level <= '0;
				baseline_valid <= 1'b0;
				confirm_level <= '0;
				stall_res <= 1'b0;
			end else begin
				mean_load <= in_mean;
				baseline_level <= latch ? in_mean : base_q;
				baseline_valid <= latch || flag_q;
				confirm_level <= cnt_nx;
				stall_res <= stall;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule
